// File: rtl/core/lkv_pkg.sv
// Package: shared sizes, codes and cell control types for the LRU key-value cache.
`timescale 1ns / 1ps
package lkv_pkg;

  // Store geometry
  localparam int ENTRIES = 16;
  localparam int AGE_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int DATA_W  = 32;
  localparam int CAP_W   = 5;

  // Capacity register reset value
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Operation codes
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  // Returned data for a get miss and for any put
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;
  localparam logic [DATA_W-1:0] PUT_VALUE  = '0;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } state_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic             capture;     // latch key compare
    logic             apply;       // commit the update
    logic             touch;       // request hit: make matched entry most recent
    logic             write_value; // put hit: overwrite value
    logic             insert;      // put miss: insert new entry
    logic             evict;       // store full: drop oldest ranks
    logic [AGE_W-1:0] hit_age;     // rank of the matched entry
    logic [CNT_W-1:0] evict_floor; // ranks at or above this are dropped
  } cell_cmd_t;

  // Status reported by each cell
  typedef struct packed {
    logic              valid;
    logic              match;
    logic [AGE_W-1:0]  age;
    logic [DATA_W-1:0] value;
  } cell_stat_t;

  // Clamp the capacity register into 1..ENTRIES
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (int'(c) > ENTRIES) begin
      r = CNT_W'(ENTRIES);
    end else begin
      r = CNT_W'(c);
    end
    return r;
  endfunction

endpackage

// File: rtl/core/lkv_cell.sv
// One store cell: holds a key, value, valid mark and recency rank.
`timescale 1ns / 1ps
module lkv_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  lkv_pkg::cell_cmd_t        cmd,
  input  logic [lkv_pkg::DATA_W-1:0] req_key,
  input  logic [lkv_pkg::DATA_W-1:0] req_value,
  input  logic                      claim_in,
  output logic                      claim_out,
  output lkv_pkg::cell_stat_t       stat
);
  import lkv_pkg::*;

  logic              valid;
  logic              match;
  logic [AGE_W-1:0]  age;
  logic [DATA_W-1:0] key;
  logic [DATA_W-1:0] value;

  logic evict_me;
  logic keep;
  logic take;

  // Decide eviction and free-slot claim along the chain
  always_comb begin
    evict_me  = cmd.evict && valid && (CNT_W'(age) >= cmd.evict_floor);
    keep      = valid && !evict_me;
    take      = !keep && !claim_in;
    claim_out = claim_in || !keep;
  end

  // Control state: valid mark, compare flag, rank
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
      age   <= '0;
    end else begin
      if (cmd.capture) begin
        match <= valid && (key == req_key);
      end
      if (cmd.apply && cmd.touch) begin
        if (match) begin
          age <= '0;
        end else if (valid && (age < cmd.hit_age)) begin
          age <= age + AGE_W'(1);
        end
      end else if (cmd.apply && cmd.insert) begin
        if (take) begin
          valid <= 1'b1;
          age   <= '0;
        end else if (keep) begin
          age <= age + AGE_W'(1);
        end else begin
          valid <= 1'b0;
        end
      end
    end
  end

  // Payload: key and value
  always_ff @(posedge clk) begin
    if (cmd.apply && cmd.insert && take) begin
      key   <= req_key;
      value <= req_value;
    end else if (cmd.apply && cmd.write_value && match) begin
      value <= req_value;
    end
  end

  assign stat = '{valid: valid, match: match, age: age, value: value};

endmodule

// File: rtl/core/lru_key_value_cache_top.sv
// Top level: fully associative LRU key-value cache built from a row of cells.
//
//  channel   | ports                         | handshake
//  ----------+-------------------------------+------------------------------
//  request   | func, key, value              | start && !busy
//  result    | hit, read_value               | done, one cycle, no stall
//  config    | cfg_wdata                     | cfg_we
//
// A request runs as accept, key compare in every cell, then the
// rank/valid update. The result strobes in the cycle after the update, when
// busy is already low, so a new request can be accepted alongside it. The key
// compare is registered ahead of the update; the free-slot claim ripples
// through the cell row inside the update cycle.
// Synchronous reset clears all valid marks and ranks and sets capacity to 16.
// The receiver cannot stall: done pulses exactly once per request.
`timescale 1ns / 1ps
module lru_key_value_cache_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        func,
  input  logic [lkv_pkg::DATA_W-1:0]  key,
  input  logic [lkv_pkg::DATA_W-1:0]  value,
  input  logic                        cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0]   cfg_wdata,
  output logic                        done,
  output logic                        hit,
  output logic [lkv_pkg::DATA_W-1:0]  read_value
);
  import lkv_pkg::*;

  state_t state;
  state_t state_next;

  logic [CAP_W-1:0]  capacity;
  logic [CNT_W-1:0]  used_count;
  logic              req_func;
  logic [DATA_W-1:0] req_key;
  logic [DATA_W-1:0] req_value;

  cell_cmd_t         cmd;
  cell_stat_t        stat [ENTRIES];
  logic [ENTRIES:0]  claim;
  logic [ENTRIES-1:0] valid_mask;
  logic [ENTRIES-1:0] match_mask;

  logic              any_hit;
  logic [AGE_W-1:0]  hit_age;
  logic [DATA_W-1:0] hit_value;
  logic [CNT_W-1:0]  cap;
  logic              full;
  logic              accept;

  assign accept = start && !busy;
  assign cap    = eff_cap(capacity);
  assign full   = used_count >= cap;

  // Gather the matched entry's rank and value
  always_comb begin
    hit_age   = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      valid_mask[i] = stat[i].valid;
      match_mask[i] = stat[i].match;
      hit_age       = hit_age | (stat[i].match ? stat[i].age : '0);
      hit_value     = hit_value | (stat[i].match ? stat[i].value : '0);
    end
    any_hit = |match_mask;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_MATCH;
      ST_MATCH:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs and cell command
  always_comb begin
    busy            = 1'b1;
    cmd.capture     = 1'b0;
    cmd.apply       = 1'b0;
    unique case (state)
      ST_IDLE:   busy = 1'b0;
      ST_MATCH:  cmd.capture = 1'b1;
      ST_UPDATE: cmd.apply = 1'b1;
      default:   busy = 1'b1;
    endcase
    cmd.touch       = any_hit;
    cmd.write_value = any_hit && (req_func == FUNC_PUT);
    cmd.insert      = !any_hit && (req_func == FUNC_PUT);
    cmd.evict       = full;
    cmd.hit_age     = hit_age;
    cmd.evict_floor = cap - CNT_W'(1);
  end

  // Hold state, capacity, entry count and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      capacity   <= CAP_RESET;
      used_count <= '0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_UPDATE);
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (cmd.apply && cmd.insert) begin
        used_count <= full ? cap : used_count + CNT_W'(1);
      end
    end
  end

  // Latch request payload and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_func  <= func;
      req_key   <= key;
      req_value <= value;
    end
    if (state == ST_UPDATE) begin
      hit <= any_hit;
      if (req_func == FUNC_PUT) begin
        read_value <= PUT_VALUE;
      end else begin
        read_value <= any_hit ? hit_value : MISS_VALUE;
      end
    end
  end

  // Cell row; the free-slot claim ripples from cell 0 upward
  assign claim[0] = 1'b0;
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkv_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .req_key   (req_key),
      .req_value (req_value),
      .claim_in  (claim[g]),
      .claim_out (claim[g+1]),
      .stat      (stat[g])
    );
  end

  // Checks
  a_count_tracks_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_mask) == int'(used_count))
    else $error("used_count disagrees with valid marks");

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_mask))
    else $error("key present in more than one entry");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted request did not raise busy");

  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |=> done)
    else $error("update finished without a result strobe");

  a_insert_has_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply && cmd.insert) |-> claim[ENTRIES])
    else $error("insert found no free slot");

endmodule
